[rtl/apa_pkg.sv]
// Shared constants, types and helpers for the atan2 polynomial angle pipeline.
package apa_pkg;

  localparam int IN_WIDTH_DEF   = 16;
  localparam int ANGLE_FRAC_DEF = 13;
  localparam int RATIO_FRAC     = 15;
  // The unrounded quotient small * 2^16 / large needs 17 bits (up to 65536).
  localparam int QUOT_BITS      = RATIO_FRAC + 2;
  localparam int POLY_FRAC      = 30;
  localparam int HORNER_STEPS   = 5;
  localparam int ANGLE_INT_W    = 34;

  typedef logic signed [31:0] q30_t;
  typedef logic signed [ANGLE_INT_W-1:0] angle_q30_t;

  // Odd atan coefficients in Q2.30, highest order first.
  localparam q30_t COEF_C11 = -32'sd12585543;
  localparam q30_t HORNER_COEF [HORNER_STEPS] = '{
    32'sd56536072,
    -32'sd125018842,
    32'sd207815708,
    -32'sd357151731,
    32'sd1073717407
  };

  localparam angle_q30_t PI_Q30      = 34'sd3373259426;
  localparam angle_q30_t HALF_PI_Q30 = 34'sd1686629713;

  typedef struct packed {
    logic swap;
    logic neg;
    logic x_neg;
    logic y_neg;
    logic zero;
  } fold_flags_t;

  // Pi rounded (half up) from Q2.30 to the given number of fraction bits.
  function automatic longint pi_out(input int frac);
    longint sh;
    sh = longint'(POLY_FRAC - frac);
    return (longint'(PI_Q30) + (64'sd1 <<< (sh - 1))) >>> sh;
  endfunction

endpackage

[rtl/apa_div_stage.sv]
// One quotient bit of the pipelined restoring divider for the ratio.
module apa_div_stage import apa_pkg::*; #(
  parameter int W     = IN_WIDTH_DEF,
  parameter bit FIRST = 1'b0
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic [W-1:0]         in_rem,
  input  logic [W-1:0]         in_div,
  input  logic [QUOT_BITS-1:0] in_quot,
  input  fold_flags_t          in_flags,
  output logic                 out_valid,
  output logic [W-1:0]         out_rem,
  output logic [W-1:0]         out_div,
  output logic [QUOT_BITS-1:0] out_quot,
  output fold_flags_t          out_flags
);

  logic [W:0] rem2;
  logic [W:0] rem_sub;
  logic       qbit;

  always_comb begin
    rem2    = FIRST ? {1'b0, in_rem} : {in_rem, 1'b0};
    qbit    = rem2 >= {1'b0, in_div};
    rem_sub = qbit ? rem2 - {1'b0, in_div} : rem2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_rem   <= rem_sub[W-1:0];
      out_div   <= in_div;
      out_quot  <= {in_quot[QUOT_BITS-2:0], qbit};
      out_flags <= in_flags;
    end
  end

endmodule

[rtl/apa_horner_stage.sv]
// One Horner step: multiply by t^2, then round to Q2.30 and add the coefficient.
module apa_horner_stage import apa_pkg::*; #(
  parameter q30_t COEF = 32'sd0
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  in_valid,
  input  q30_t                  in_acc,
  input  logic [POLY_FRAC:0]    in_t2,
  input  logic [RATIO_FRAC+1:0] in_t,
  input  fold_flags_t           in_flags,
  output logic                  out_valid,
  output q30_t                  out_acc,
  output logic [POLY_FRAC:0]    out_t2,
  output logic [RATIO_FRAC+1:0] out_t,
  output fold_flags_t           out_flags
);

  logic                  mul_valid;
  logic signed [63:0]    prod;
  logic [POLY_FRAC:0]    mul_t2;
  logic [RATIO_FRAC+1:0] mul_t;
  fold_flags_t           mul_flags;
  logic signed [63:0]    rounded;

  always_comb begin
    rounded = (prod + (64'sd1 <<< (POLY_FRAC - 1))) >>> POLY_FRAC;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mul_valid <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      mul_valid <= in_valid;
      out_valid <= mul_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod      <= 64'(in_acc * $signed({1'b0, in_t2}));
      mul_t2    <= in_t2;
      mul_t     <= in_t;
      mul_flags <= in_flags;
      out_acc   <= COEF + rounded[31:0];
      out_t2    <= mul_t2;
      out_t     <= mul_t;
      out_flags <= mul_flags;
    end
  end

endmodule

[rtl/apa_fold.sv]
// Final multiply by t, octant and quadrant fold, output rounding and wrap.
module apa_fold import apa_pkg::*; #(
  parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_DEF,
  parameter int ANGLE_W         = ANGLE_FRAC_BITS + 3
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  in_valid,
  input  q30_t                  in_acc,
  input  logic [RATIO_FRAC+1:0] in_t,
  input  fold_flags_t           in_flags,
  output logic                  out_valid,
  output logic [ANGLE_W-1:0]    angle_signed,
  output logic [ANGLE_W-1:0]    angle_wrapped
);

  localparam int SHIFT = POLY_FRAC - ANGLE_FRAC_BITS;
  localparam logic [ANGLE_W-1:0] TWO_PI_OUT = ANGLE_W'(2 * pi_out(ANGLE_FRAC_BITS));

  logic               mul_valid;
  logic signed [49:0] prod;
  fold_flags_t        mul_flags;
  logic               ang_valid;
  angle_q30_t         angle;
  logic signed [49:0] atan_full;
  angle_q30_t         a_neg;
  angle_q30_t         a_oct;
  angle_q30_t         a_quad;
  angle_q30_t         angle_rnd;
  logic [ANGLE_W-1:0] s_out;

  always_comb begin
    atan_full = (prod + (50'sd1 <<< (RATIO_FRAC - 1))) >>> RATIO_FRAC;
    a_neg = mul_flags.neg ? -atan_full[ANGLE_INT_W-1:0] : atan_full[ANGLE_INT_W-1:0];
    a_oct = a_neg;
    if (mul_flags.swap) begin
      a_oct = (mul_flags.neg ? -HALF_PI_Q30 : HALF_PI_Q30) - a_neg;
    end
    a_quad = a_oct;
    if (mul_flags.x_neg) begin
      a_quad = a_oct + (mul_flags.y_neg ? -PI_Q30 : PI_Q30);
    end
    if (mul_flags.zero) begin
      a_quad = '0;
    end
    angle_rnd = (angle + (angle_q30_t'(1) <<< (SHIFT - 1))) >>> SHIFT;
    s_out     = angle_rnd[ANGLE_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mul_valid <= 1'b0;
      ang_valid <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      mul_valid <= in_valid;
      ang_valid <= mul_valid;
      out_valid <= ang_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod          <= 50'(in_acc * $signed({1'b0, in_t}));
      mul_flags     <= in_flags;
      angle         <= a_quad;
      angle_signed  <= s_out;
      angle_wrapped <= s_out[ANGLE_W-1] ? s_out + TWO_PI_OUT : s_out;
    end
  end

endmodule

[rtl/atan2_poly_angle.sv]
// Top level of the atan2 polynomial angle pipeline.
// Each request (y_value, x_value) yields one angle in radians with ANGLE_FRAC_BITS fraction
// bits, signed in (-pi, pi] and wrapped to [0, 2pi); the zero vector gives 0. The pipeline
// takes one request per clock unless the output holds a result that is not taken, and has
// 32 register stages: one input stage, 17 divider stages (one quotient bit each), one t^2
// stage, five two-stage Horner steps and three stages for the last multiply, fold and
// rounding. When the result is not taken, the whole pipeline holds.
module atan2_poly_angle import apa_pkg::*; #(
  parameter int IN_WIDTH        = IN_WIDTH_DEF,
  parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [IN_WIDTH-1:0]          y_value,
  input  logic [IN_WIDTH-1:0]          x_value,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [ANGLE_FRAC_BITS+2:0]   angle_signed,
  output logic [ANGLE_FRAC_BITS+2:0]   angle_wrapped
);

  localparam int ANGLE_W = ANGLE_FRAC_BITS + 3;

  logic                en;
  logic [IN_WIDTH-1:0] ax;
  logic [IN_WIDTH-1:0] ay;
  fold_flags_t         in_flags;

  logic                 div_v [QUOT_BITS+1];
  logic [IN_WIDTH-1:0]  div_r [QUOT_BITS+1];
  logic [IN_WIDTH-1:0]  div_l [QUOT_BITS+1];
  logic [QUOT_BITS-1:0] div_q [QUOT_BITS+1];
  fold_flags_t          div_f [QUOT_BITS+1];

  logic [QUOT_BITS:0]    t_sum;
  logic [RATIO_FRAC+1:0] t_next;

  logic                  h_v  [HORNER_STEPS+1];
  q30_t                  h_a  [HORNER_STEPS+1];
  logic [POLY_FRAC:0]    h_t2 [HORNER_STEPS+1];
  logic [RATIO_FRAC+1:0] h_t  [HORNER_STEPS+1];
  fold_flags_t           h_f  [HORNER_STEPS+1];

  assign en       = ~out_valid | out_ready;
  assign in_ready = en;

  always_comb begin
    ay = y_value[IN_WIDTH-1] ? (~y_value + 1'b1) : y_value;
    ax = x_value[IN_WIDTH-1] ? (~x_value + 1'b1) : x_value;
    in_flags.swap  = ax < ay;
    in_flags.neg   = x_value[IN_WIDTH-1] ^ y_value[IN_WIDTH-1];
    in_flags.x_neg = x_value[IN_WIDTH-1];
    in_flags.y_neg = y_value[IN_WIDTH-1];
    in_flags.zero  = (ax == '0) && (ay == '0);
  end

  // Input stage: magnitudes sorted into numerator and divisor.
  always_ff @(posedge clk) begin
    if (rst) begin
      div_v[0] <= 1'b0;
    end else if (en) begin
      div_v[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      div_r[0] <= in_flags.swap ? ax : ay;
      div_l[0] <= in_flags.swap ? ay : ax;
      div_q[0] <= '0;
      div_f[0] <= in_flags;
    end
  end

  for (genvar k = 0; k < QUOT_BITS; k++) begin : g_div
    apa_div_stage #(
      .W     (IN_WIDTH),
      .FIRST (k == 0)
    ) u_div (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (div_v[k]),
      .in_rem    (div_r[k]),
      .in_div    (div_l[k]),
      .in_quot   (div_q[k]),
      .in_flags  (div_f[k]),
      .out_valid (div_v[k+1]),
      .out_rem   (div_r[k+1]),
      .out_div   (div_l[k+1]),
      .out_quot  (div_q[k+1]),
      .out_flags (div_f[k+1])
    );
  end

  // Halving the 17-bit quotient with a carry in gives the ratio rounded half up.
  always_comb begin
    t_sum  = {1'b0, div_q[QUOT_BITS]} + 1'b1;
    t_next = t_sum[QUOT_BITS:1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      h_v[0] <= 1'b0;
    end else if (en) begin
      h_v[0] <= div_v[QUOT_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      h_a[0]  <= COEF_C11;
      h_t2[0] <= (POLY_FRAC+1)'(t_next * t_next);
      h_t[0]  <= t_next;
      h_f[0]  <= div_f[QUOT_BITS];
    end
  end

  for (genvar k = 0; k < HORNER_STEPS; k++) begin : g_horner
    apa_horner_stage #(
      .COEF (HORNER_COEF[k])
    ) u_step (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (h_v[k]),
      .in_acc    (h_a[k]),
      .in_t2     (h_t2[k]),
      .in_t      (h_t[k]),
      .in_flags  (h_f[k]),
      .out_valid (h_v[k+1]),
      .out_acc   (h_a[k+1]),
      .out_t2    (h_t2[k+1]),
      .out_t     (h_t[k+1]),
      .out_flags (h_f[k+1])
    );
  end

  apa_fold #(
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
    .ANGLE_W         (ANGLE_W)
  ) u_fold (
    .clk           (clk),
    .rst           (rst),
    .en            (en),
    .in_valid      (h_v[HORNER_STEPS]),
    .in_acc        (h_a[HORNER_STEPS]),
    .in_t          (h_t[HORNER_STEPS]),
    .in_flags      (h_f[HORNER_STEPS]),
    .out_valid     (out_valid),
    .angle_signed  (angle_signed),
    .angle_wrapped (angle_wrapped)
  );

endmodule

[sim/atan2_poly_angle_tb.sv]
// Self-checking testbench for the atan2 polynomial angle pipeline.
module atan2_poly_angle_tb;
  import apa_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IW = 16;
  localparam int AF = 13;
  localparam int AW = AF + 3;
  localparam int LATENCY = 33;
  localparam int N_RANDOM = 2000;
  localparam longint CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [AW-1:0] signed_ang;
    logic [AW-1:0] wrapped_ang;
  } angle_pair_t;

  // Rounds v / 2^s to nearest with halves toward plus infinity.
  function automatic longint rnd_shift(longint v, int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic longint e8_to_q30(longint n);
    return ((n <<< 30) + 50000000) / 100000000;
  endfunction

  function automatic longint atan_ratio(longint t);
    longint t2;
    longint acc;
    t2 = t * t;
    acc = -e8_to_q30(1172120);
    acc = e8_to_q30(5265332) + rnd_shift(acc * t2, 30);
    acc = -e8_to_q30(11643287) + rnd_shift(acc * t2, 30);
    acc = e8_to_q30(19354346) + rnd_shift(acc * t2, 30);
    acc = -e8_to_q30(33262347) + rnd_shift(acc * t2, 30);
    acc = e8_to_q30(99997726) + rnd_shift(acc * t2, 30);
    return rnd_shift(acc * t, 15);
  endfunction

  function automatic angle_pair_t predict_angle(logic signed [IW-1:0] y,
                                                logic signed [IW-1:0] x);
    longint yl, xl, ay, ax, sm, lg, t, a, so, pio, hpi, piq;
    logic swp, ng;
    angle_pair_t r;
    piq = 64'sd3373259426;
    hpi = 64'sd1686629713;
    yl = y;
    xl = x;
    ay = yl < 0 ? -yl : yl;
    ax = xl < 0 ? -xl : xl;
    a = 0;
    if (ax != 0 || ay != 0) begin
      swp = ax < ay;
      sm = swp ? ax : ay;
      lg = swp ? ay : ax;
      ng = (xl < 0) != (yl < 0);
      t = ((sm <<< 16) + lg) / (lg <<< 1);
      a = atan_ratio(t);
      if (ng) a = -a;
      if (swp) a = (ng ? -hpi : hpi) - a;
      if (xl < 0) a = (yl >= 0 ? piq : -piq) + a;
    end
    pio = rnd_shift(piq, 30 - AF);
    so = rnd_shift(a, 30 - AF);
    r.signed_ang = so[AW-1:0];
    r.wrapped_ang = so < 0 ? AW'(so + 2 * pio) : so[AW-1:0];
    return r;
  endfunction

  class angle_scoreboard;
    angle_pair_t pending[$];
    int errors;

    function void note_request(logic [IW-1:0] y, logic [IW-1:0] x);
      pending.push_back(predict_angle(y, x));
    endfunction

    function void check_result(logic [AW-1:0] s, logic [AW-1:0] w);
      angle_pair_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result signed=%0d wrapped=%0d", $time, s, w);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (e.signed_ang !== s) begin
        $display("%0t: angle_signed expected %0d actual %0d", $time,
                 $signed(e.signed_ang), $signed(s));
        errors++;
      end
      if (e.wrapped_ang !== w) begin
        $display("%0t: angle_wrapped expected %0d actual %0d", $time, e.wrapped_ang, w);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [IW-1:0] y_value = '0;
  logic [IW-1:0] x_value = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [AW-1:0] angle_signed;
  logic [AW-1:0] angle_wrapped;
  bit calm = 1'b0;
  longint cycles = 0;
  angle_scoreboard sb = new();

  atan2_poly_angle uut (.*);

  initial begin
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("atan2_poly_angle_tb failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_result(angle_signed, angle_wrapped);
  end

  // The receiver stalls at random except during the calm stretch.
  always @(negedge clk) begin
    if (rst) out_ready <= 1'b0;
    else out_ready <= calm || ($urandom_range(99) >= 20);
  end

  // Valid stays high between back-to-back requests; idle cycles and the drain lower it.
  task automatic send_request(logic [IW-1:0] y, logic [IW-1:0] x);
    while (!calm && $urandom_range(99) < 20) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    y_value <= y;
    x_value <= x;
    do @(posedge clk); while (!in_ready);
    sb.note_request(y, x);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
  endtask

  function automatic logic [IW-1:0] rand_component();
    case ($urandom_range(5))
      0: return IW'($urandom_range(7)) - IW'(4);
      1: return $urandom_range(1) ? 16'h8000 : 16'h7fff;
      default: return IW'($urandom());
    endcase
  endfunction

  initial begin
    logic [IW-1:0] a;
    logic [IW-1:0] dir_y [] = '{0, 0, 100, 16'hff9c, 0, 16'h8000, 16'h7fff, 16'h8000,
                                16'h7fff, 16'h8000, 5, 16'hfffb, 16'hfffb, 1, 16'h7fff,
                                1, 16'hffff, 16'h4000};
    logic [IW-1:0] dir_x [] = '{0, 100, 0, 0, 16'hff9c, 16'h8000, 16'h7fff, 16'h7fff,
                                16'h8000, 0, 5, 5, 16'hfffb, 16'h7fff, 1, 16'h8000,
                                16'h8000, 16'hc001};
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    foreach (dir_y[i]) send_request(dir_y[i], dir_x[i]);
    wait_drained();
    for (int i = 0; i < N_RANDOM; i++) begin
      calm = (i >= 600 && i < 900);
      if (i == 1200) wait_drained();
      if ($urandom_range(9) == 0) begin
        a = rand_component();
        send_request(a, $urandom_range(1) ? a : -a);
      end else begin
        send_request(rand_component(), rand_component());
      end
    end
    calm = 1'b1;
    wait_drained();
    repeat (LATENCY + 10) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) $display("atan2_poly_angle_tb passed");
    else $display("atan2_poly_angle_tb failed");
    $finish;
  end
endmodule

[sim.f]
rtl/apa_pkg.sv
rtl/apa_div_stage.sv
rtl/apa_horner_stage.sv
rtl/apa_fold.sv
rtl/atan2_poly_angle.sv
sim/atan2_poly_angle_tb.sv
